/* hdl/quaternion_normalize_top_defines.svh */
// assertion macros for the quaternion normalizer
`ifndef QUATERNION_NORMALIZE_TOP_DEFINES_SVH
`define QUATERNION_NORMALIZE_TOP_DEFINES_SVH

// concurrent check of an implication, synchronous reset disables it
`define QN_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("quaternion normalizer check failed");

// check of an implication in the cycle after the antecedent
`define QN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("quaternion normalizer check failed");

`endif

/* hdl/qn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qn_pkg
// shared constants and types of the quaternion normalizer
// ----------------------------------------------------------------------------
package qn_pkg;

   localparam int COMPONENT_BITS_DEF = 16;
   localparam int LANES = 4;

   typedef struct packed {
      logic             valid;
      logic             zero;
      logic [LANES-1:0] neg;
   } qn_ctrl_type;

endpackage

/* hdl/qn_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qn_front
// magnitudes, squares and sum of squares, seeds the bit cells
// ----------------------------------------------------------------------------
module qn_front import qn_pkg::*; #(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      en,
   input  logic                                      in_valid,
   input  logic [LANES-1:0][COMPONENT_BITS-1:0]      comp,
   output qn_ctrl_type                               ctrl_out,
   output logic [2*COMPONENT_BITS+1:0]               sum_out,
   output logic signed [LANES-1:0][4*COMPONENT_BITS+1:0] x_out,
   output logic signed [LANES-1:0][4*COMPONENT_BITS+1:0] g_out
);

   localparam int B  = COMPONENT_BITS;
   localparam int F  = B - 2;
   localparam int SW = 2 * B + 2;
   localparam int W  = 4 * B + 2;

   qn_ctrl_type c1_ff, c1_in, c2_ff, c3_ff;
   logic [LANES-1:0][B-1:0]   mag_ff, mag_in;
   logic [LANES-1:0][2*B-1:0] sq_ff, sq_in;
   logic [SW-1:0]             sum_ff, sum_in;
   logic signed [LANES-1:0][W-1:0] x_ff, x_in, g_ff, g_in;

   always_comb begin
      c1_in.valid = in_valid;
      c1_in.zero  = 1'b1;
      for (int i = 0; i < LANES; i++) begin
         c1_in.neg[i] = comp[i][B-1];
         mag_in[i]    = comp[i][B-1] ? (~comp[i] + 1'b1) : comp[i];
         if (comp[i] != '0) begin
            c1_in.zero = 1'b0;
         end
      end
      for (int i = 0; i < LANES; i++) begin
         sq_in[i] = (2*B)'(mag_ff[i]) * (2*B)'(mag_ff[i]);
      end
      sum_in = '0;
      for (int i = 0; i < LANES; i++) begin
         sum_in = sum_in + SW'(sq_ff[i]);
      end
      for (int i = 0; i < LANES; i++) begin
         x_in[i] = (W'(sq_ff[i]) << (2 * F + 2)) - W'(sum_in);
         g_in[i] = -$signed(W'(sum_in));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff.valid <= 1'b0;
         c2_ff.valid <= 1'b0;
         c3_ff.valid <= 1'b0;
      end else if (en) begin
         c1_ff.valid <= c1_in.valid;
         c2_ff.valid <= c1_ff.valid;
         c3_ff.valid <= c2_ff.valid;
      end
      if (en) begin
         c1_ff.zero <= c1_in.zero;
         c1_ff.neg  <= c1_in.neg;
         c2_ff.zero <= c1_ff.zero;
         c2_ff.neg  <= c1_ff.neg;
         c3_ff.zero <= c2_ff.zero;
         c3_ff.neg  <= c2_ff.neg;
         mag_ff     <= mag_in;
         sq_ff      <= sq_in;
         sum_ff     <= sum_in;
         x_ff       <= x_in;
         g_ff       <= g_in;
      end
   end

   assign ctrl_out = c3_ff;
   assign sum_out  = sum_ff;
   assign x_out    = x_ff;
   assign g_out    = g_ff;

endmodule

/* hdl/qn_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qn_cell
// decides one result bit of every lane and updates the running margin
// ----------------------------------------------------------------------------
module qn_cell import qn_pkg::*; #(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
   parameter int BIT_POS        = 0
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          en,
   input  qn_ctrl_type                                   ctrl_in,
   input  logic [2*COMPONENT_BITS+1:0]                   sum_in,
   input  logic signed [LANES-1:0][4*COMPONENT_BITS+1:0] x_in,
   input  logic signed [LANES-1:0][4*COMPONENT_BITS+1:0] g_in,
   input  logic [LANES-1:0][COMPONENT_BITS-2:0]          n_in,
   output qn_ctrl_type                                   ctrl_out,
   output logic [2*COMPONENT_BITS+1:0]                   sum_out,
   output logic signed [LANES-1:0][4*COMPONENT_BITS+1:0] x_out,
   output logic signed [LANES-1:0][4*COMPONENT_BITS+1:0] g_out,
   output logic [LANES-1:0][COMPONENT_BITS-2:0]          n_out
);

   localparam int B  = COMPONENT_BITS;
   localparam int SW = 2 * B + 2;
   localparam int W  = 4 * B + 2;
   localparam int NB = B - 1;

   qn_ctrl_type ctrl_ff;
   logic [SW-1:0] sum_ff;
   logic signed [LANES-1:0][W-1:0] x_ff, x_nx, g_ff, g_nx;
   logic [LANES-1:0][NB-1:0] n_ff, n_nx;
   logic signed [W-1:0] sum_w, trial;

   always_comb begin
      sum_w = $signed(W'(sum_in));
      for (int i = 0; i < LANES; i++) begin
         // margin left if this bit is set
         trial = x_in[i] - (g_in[i] <<< (BIT_POS + 2)) - (sum_w <<< (2 * BIT_POS + 2));
         if (!trial[W-1]) begin
            x_nx[i] = trial;
            g_nx[i] = g_in[i] + (sum_w <<< (BIT_POS + 1));
            n_nx[i] = n_in[i] | (NB'(1) << BIT_POS);
         end else begin
            x_nx[i] = x_in[i];
            g_nx[i] = g_in[i];
            n_nx[i] = n_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (en) begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
      if (en) begin
         ctrl_ff.zero <= ctrl_in.zero;
         ctrl_ff.neg  <= ctrl_in.neg;
         sum_ff       <= sum_in;
         x_ff         <= x_nx;
         g_ff         <= g_nx;
         n_ff         <= n_nx;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign sum_out  = sum_ff;
   assign x_out    = x_ff;
   assign g_out    = g_ff;
   assign n_out    = n_ff;

endmodule

/* hdl/quaternion_normalize_top.sv */
`timescale 1ns / 1ps
// pipeline: three front stages, one bit cell per result bit, COMPONENT_BITS - 1
// of them, and the output register
// throughput: one request per cycle unless a held result stalls the pipeline
// reset clears all valid flags and sets inv_ff to 0
// ----------------------------------------------------------------------------
// quaternion_normalize_top
// normalizes a Q2.F quaternion, optional conjugate, zero-norm flag
// ----------------------------------------------------------------------------
`include "quaternion_normalize_top_defines.svh"

module quaternion_normalize_top import qn_pkg::*; #(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_wen,
   input  logic csr_wdata,
   input  logic req_tvalid,
   output logic req_tready,
   // comp_w, comp_x, comp_y, comp_z
   input  logic [((LANES*COMPONENT_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // unit_w, unit_x, unit_y, unit_z
   output logic [((LANES*COMPONENT_BITS+7)/8)*8-1:0] rsp_tdata,
   // zero_norm
   output logic rsp_tuser
);

   localparam int B  = COMPONENT_BITS;
   localparam int F  = B - 2;
   localparam int SW = 2 * B + 2;
   localparam int W  = 4 * B + 2;
   localparam int NB = B - 1;
   localparam int DW = ((LANES * B + 7) / 8) * 8;
   localparam int NC = NB;

   logic en;
   logic inv_ff;
   logic [LANES-1:0][B-1:0] comp;

   qn_ctrl_type ctrl [0:NC];
   logic [SW-1:0] sum [0:NC];
   logic signed [LANES-1:0][W-1:0] xs [0:NC];
   logic signed [LANES-1:0][W-1:0] gs [0:NC];
   logic [LANES-1:0][NB-1:0] ns [0:NC];

   logic            vld_ff;
   logic [DW-1:0]   data_ff, data_in;
   logic            zero_ff;
   logic [LANES-1:0][B-1:0] unit;

   assign en         = !vld_ff || rsp_tready;
   assign req_tready = en;
   assign comp       = req_tdata[LANES*B-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= 1'b0;
      end else if (csr_wen) begin
         inv_ff <= csr_wdata;
      end
   end

   qn_front #(.COMPONENT_BITS(B)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .comp     (comp),
      .ctrl_out (ctrl[0]),
      .sum_out  (sum[0]),
      .x_out    (xs[0]),
      .g_out    (gs[0])
   );

   assign ns[0] = '0;

   for (genvar k = 0; k < NC; k++) begin : g_cell
      qn_cell #(.COMPONENT_BITS(B), .BIT_POS(NB - 1 - k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .ctrl_in  (ctrl[k]),
         .sum_in   (sum[k]),
         .x_in     (xs[k]),
         .g_in     (gs[k]),
         .n_in     (ns[k]),
         .ctrl_out (ctrl[k+1]),
         .sum_out  (sum[k+1]),
         .x_out    (xs[k+1]),
         .g_out    (gs[k+1]),
         .n_out    (ns[k+1])
      );
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if ((ctrl[NC].neg[i] ^ (inv_ff && (i > 0))) == 1'b1) begin
            unit[i] = ~B'(ns[NC][i]) + 1'b1;
         end else begin
            unit[i] = B'(ns[NC][i]);
         end
      end
      if (ctrl[NC].zero) begin
         unit    = '0;
         unit[0] = inv_ff ? '0 : (B'(1) << F);
      end
      data_in = DW'(unit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= ctrl[NC].valid;
      end
      if (en) begin
         data_ff <= data_in;
         zero_ff <= ctrl[NC].zero;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = zero_ff;

   `QN_ASSERT_IMPL(a_zero_vec, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[LANES*B-1:B] == '0)
   `QN_ASSERT_IMPL(a_no_minneg, clock, reset, rsp_tvalid, rsp_tdata[B-1:0] != (B'(1) << (B - 1)))
   `QN_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

/* bench/quaternion_normalize_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_normalize_checker
// watches the request and result streams of the quaternion normalizer,
// predicts each unit quaternion with exact integer rounding and compares
// every accepted result field by field against the oldest prediction
// ----------------------------------------------------------------------------
module quaternion_normalize_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic        csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          failures,
   output int          pending,
   output int          checked,
   output int          zeros_seen
);

   typedef struct {
      logic [15:0] w;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
      logic        zero;
   } unit_quat_t;

   unit_quat_t unit_queue[$];
   logic       conj_mode;

   // largest n <= mag * 2^14 / sqrt(sum) + 1/2, capped at 2^14
   function automatic logic [15:0] rounded_scale(logic [15:0] mag,
                                                 logic [63:0] sum);
      logic [127:0] lhs;
      logic [127:0] rhs;
      logic [127:0] t;
      int           lo;
      int           hi;
      int           mid;
      lo  = 0;
      hi  = 16384;
      rhs = (128'(mag) * 128'(mag)) << 30;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         t   = 128'(2 * mid - 1);
         lhs = t * t * 128'(sum);
         if (lhs <= rhs) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return 16'(lo);
   endfunction

   function automatic unit_quat_t normalize(logic [63:0] data, logic conj);
      unit_quat_t  res;
      logic [15:0] comp [4];
      logic [15:0] mag  [4];
      logic [15:0] outv [4];
      logic [63:0] sum;
      logic        neg;
      sum = 0;
      for (int i = 0; i < 4; i++) begin
         comp[i] = data[16*i +: 16];
         mag[i]  = comp[i][15] ? (~comp[i] + 16'd1) : comp[i];
         sum     = sum + 64'(mag[i]) * 64'(mag[i]);
      end
      if (sum == 0) begin
         res.w    = conj ? 16'd0 : 16'd16384;
         res.x    = 16'd0;
         res.y    = 16'd0;
         res.z    = 16'd0;
         res.zero = 1'b1;
         return res;
      end
      for (int i = 0; i < 4; i++) begin
         neg     = comp[i][15] ^ (conj && i > 0);
         outv[i] = rounded_scale(mag[i], sum);
         if (neg) outv[i] = ~outv[i] + 16'd1;
      end
      res.w    = outv[0];
      res.x    = outv[1];
      res.y    = outv[2];
      res.z    = outv[3];
      res.zero = 1'b0;
      return res;
   endfunction

   always @(posedge clock) begin
      unit_quat_t want;
      if (reset) begin
         conj_mode = 1'b0;
         unit_queue.delete();
      end else begin
         if (csr_wen) conj_mode = csr_wdata;
         if (req_tvalid && req_tready) unit_queue.push_back(normalize(req_tdata, conj_mode));
         if (rsp_tvalid && rsp_tready) begin
            if (unit_queue.size() == 0) begin
               $error("unexpected result tdata=%h tuser=%b", rsp_tdata, rsp_tuser);
               failures++;
            end else begin
               want = unit_queue.pop_front();
               checked++;
               if (want.zero) zeros_seen++;
               if (rsp_tdata[15:0] !== want.w) begin
                  $error("unit_w expected %h actual %h", want.w, rsp_tdata[15:0]);
                  failures++;
               end
               if (rsp_tdata[31:16] !== want.x) begin
                  $error("unit_x expected %h actual %h", want.x, rsp_tdata[31:16]);
                  failures++;
               end
               if (rsp_tdata[47:32] !== want.y) begin
                  $error("unit_y expected %h actual %h", want.y, rsp_tdata[47:32]);
                  failures++;
               end
               if (rsp_tdata[63:48] !== want.z) begin
                  $error("unit_z expected %h actual %h", want.z, rsp_tdata[63:48]);
                  failures++;
               end
               if (rsp_tuser !== want.zero) begin
                  $error("zero_norm expected %b actual %b", want.zero, rsp_tuser);
                  failures++;
               end
            end
         end
      end
      pending <= unit_queue.size();
   end

   initial begin
      failures   = 0;
      pending    = 0;
      checked    = 0;
      zeros_seen = 0;
      conj_mode  = 1'b0;
   end

endmodule

/* bench/quaternion_normalize_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_normalize_top_tb
// drives directed and random quaternions through the normalizer in both
// modes with random gaps and stalls on both streams; the checker predicts
// and compares, this module reports the verdict
// ----------------------------------------------------------------------------
module quaternion_normalize_top_tb;

   localparam int LATENCY = 19;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic        csr_wdata = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;

   int failures;
   int pending;
   int checked;
   int zeros_seen;
   int sent = 0;
   int mode_writes = 0;

   always #1 clock = ~clock;

   quaternion_normalize_top DUT (
      .clock(clock), .reset(reset), .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   quaternion_normalize_checker checker_i (
      .clock(clock), .reset(reset), .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .failures(failures), .pending(pending),
      .checked(checked), .zeros_seen(zeros_seen)
   );

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] rand_comp(int kind);
      case (kind)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 128) - 64);
         2: return ($urandom_range(0, 1) ? 16'h8000 : 16'h7fff) ^ 16'($urandom_range(0, 3));
         default: return 16'd0;
      endcase
   endfunction

   // one request, valid stays up when the next one follows without a gap
   task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                            logic [15:0] z, bit allow_gap);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x, w};
      forever begin
         @(negedge clock);
         if (req_tready) break;
      end
      @(posedge clock);
      sent++;
      gap = allow_gap ? gap_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_and_set_mode(logic m);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_wen   <= 1'b0;
      mode_writes++;
   endtask

   task automatic directed_set();
      send_quat(16'd0, 16'd0, 16'd0, 16'd0, 1);
      send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1);
      send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
      send_quat(16'h8000, 16'd0, 16'd0, 16'd0, 0);
      send_quat(16'd0, 16'h8000, 16'd0, 16'd0, 1);
      send_quat(16'd0, 16'd0, 16'h7fff, 16'd0, 0);
      send_quat(16'd0, 16'd0, 16'd0, 16'hffff, 1);
      send_quat(16'd1, 16'd0, 16'd0, 16'd0, 0);
      send_quat(16'd16384, 16'd0, 16'd0, 16'd0, 1);
      send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0);
      send_quat(16'd1, 16'hffff, 16'd1, 16'hffff, 1);
      send_quat(16'h7fff, 16'd1, 16'd0, 16'd0, 0);
      send_quat(16'd3, 16'd4, 16'd0, 16'd0, 1);
   endtask

   task automatic random_set(int count);
      int          kind;
      int          sel;
      logic [15:0] c [4];
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         kind = (sel < 50) ? 0 : (sel < 72) ? 1 : (sel < 95) ? 2 : 3;
         for (int i = 0; i < 4; i++) c[i] = rand_comp(kind);
         if (sel >= 72 && sel < 85) begin
            // one dominant component, the rest small
            for (int i = 0; i < 4; i++) c[i] = rand_comp(1);
            c[$urandom_range(0, 3)] = rand_comp(0);
         end
         send_quat(c[0], c[1], c[2], c[3], 1);
      end
   endtask

   // result side: random readiness plus one long hold once traffic builds
   initial begin
      int  r;
      bit  held;
      held = 0;
      @(negedge reset);
      forever begin
         if (!held && checked >= 300) begin
            held = 1;
            rsp_tready <= 1'b0;
            for (int k = 0; k < 400; k++) @(posedge clock);
         end
         r = $urandom_range(0, 99);
         rsp_tready <= (r >= 30);
         if (r < 20) begin
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else if (r < 30) begin
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_set();
      drain_and_set_mode(1'b1);
      directed_set();
      random_set(250);
      drain_and_set_mode(1'b0);
      random_set(250);
      // sender waits for every outstanding result before going on
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      random_set(100);
      drain_and_set_mode(1'b1);
      random_set(200);
      drain_and_set_mode(1'b0);
      random_set(150);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("covered %0d requests, %0d results checked, %0d zero-norm, %0d mode writes",
               sent, checked, zeros_seen, mode_writes);
      if (failures == 0 && pending == 0) begin
         $display("[quaternion_normalize_top] OK");
      end else begin
         $display("[quaternion_normalize_top] ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d results outstanding", pending);
      $display("[quaternion_normalize_top] ERROR");
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/qn_pkg.sv
hdl/qn_front.sv
hdl/qn_cell.sv
hdl/quaternion_normalize_top.sv
bench/quaternion_normalize_checker.sv
bench/quaternion_normalize_top_tb.sv
